// ===== design/tcw_pkg.sv =====
// Shared constants, codes and control types of the text console writer.
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int COPY_N     = CELL_COUNT - COLUMNS;

  // Internal widths
  localparam int CELL_W = $clog2(CELL_COUNT);
  localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W  = $clog2(ROWS);

  // Port field widths
  localparam int IDX_W       = 11;
  localparam int OUT_COL_W   = 7;
  localparam int OUT_ROW_W   = 5;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  // Character codes and reset attribute
  localparam logic [7:0] NL_CODE     = 8'd10;
  localparam logic [7:0] CR_CODE     = 8'd13;
  localparam logic [7:0] SPACE_CODE  = 8'd32;
  localparam logic [7:0] COLOR_RESET = 8'h0F;

  // Item operations
  localparam logic OP_PRINT = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic latch_item;
    logic exec_print;
    logic exec_read;
    logic cnt_zero;
    logic cnt_inc;
    logic copy_step;
    logic fill_step;
    logic fill_blank;
    logic load_out;
    logic out_cr;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic op_read;
    logic is_newline;
    logic scroll_needed;
    logic copy_done;
    logic fill_done;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== design/text_console_writer_core.sv =====
// Top level of the text console writer: controller and datapath.
//
// Input stream: each word is a print (in_tuser low, character in in_tdata) or a
// cell read (in_tuser high, cell index in in_tdata). A print stores the
// character with the current attribute at the cursor and echoes it; a newline
// echoes 10 and then 13 as two words, the first with tlast low. A read returns
// the stored character and attribute with the serial flag low.
// Configuration: cfg_wen with cfg_wdata sets the attribute byte (reset 0x0F).
// Timing: one item at a time. An ordinary print or read is executed, then its
// result word is loaded, and only then is the next item taken; a newline
// loads its carriage return in a further emit step after the first word. A
// step past the bottom row adds a sweep of the store: the screen store has
// one read and one write port, so the row shift moves one cell a cycle, then
// the bottom row is filled one cell a cycle.
// Reset: cursor to the top left; the store is then cleared to zero while
// in_tready is low; configuration writes are taken meanwhile.
// Stall: the result register holds its word while out_tready is low; a new
// item is accepted meanwhile and waits at its emit step for the register.
module text_console_writer_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [7:0] char_code, [18:8] cell_index, [23:19] zero
  input  logic [tcw_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [0] opcode
  input  logic                              in_tuser,
  input  logic                              cfg_wen,
  input  logic [7:0]                        cfg_wdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] serial_byte, [15:8] cell_char, [23:16] cell_attr,
  // [30:24] cursor_col, [35:31] cursor_row, [39:36] zero
  output logic [tcw_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // [0] serial_valid
  output logic                              out_tuser,
  output logic                              out_tlast
);
  import tcw_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcw_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTH
  // A result is only loaded into a free register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over a pending word");

  // No item is taken while the store is being swept
  a_no_accept_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !(cmd.copy_step || cmd.fill_step))
    else $error("item accepted during a store sweep");

  // No item is taken while the first newline word waits for its carriage return
  a_nl_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> !in_tready)
    else $error("input reopened before carriage return was sent");

  // Read results carry no serial byte and close their item
  a_read_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tlast && out_tdata[7:0] == 8'h00))
    else $error("malformed read result");
`endif

endmodule

// ===== design/tcw_ctrl.sv =====
// Sequencing state machine of the text console writer.
module tcw_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  tcw_pkg::dp_sts_t sts,
  output tcw_pkg::dp_cmd_t cmd
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_FILL,
    ST_EMIT,
    ST_EMIT_CR
  } state_t;

  state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == ST_IDLE);

  // Decode commands and next state
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_done) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.latch_item = 1'b1;
          state_nxt      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.op_read) begin
          cmd.exec_read = 1'b1;
          state_nxt     = ST_EMIT;
        end else begin
          cmd.exec_print = 1'b1;
          cmd.cnt_zero   = 1'b1;
          state_nxt      = sts.scroll_needed ? ST_SCROLL : ST_EMIT;
        end
      end
      ST_SCROLL: begin
        cmd.copy_step = 1'b1;
        if (sts.copy_done) begin
          state_nxt = ST_FILL;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      ST_FILL: begin
        cmd.fill_step  = 1'b1;
        cmd.fill_blank = 1'b1;
        if (sts.fill_done) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = sts.is_newline ? ST_EMIT_CR : ST_IDLE;
        end
      end
      ST_EMIT_CR: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_cr   = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/tcw_datapath.sv =====
// Screen store, cursor, sweep counter and result register of the text console writer.
module tcw_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [tcw_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                in_tuser,
  input  logic                                cfg_wen,
  input  logic [7:0]                          cfg_wdata,
  input  tcw_pkg::dp_cmd_t                    cmd,
  output tcw_pkg::dp_sts_t                    sts,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tcw_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tuser,
  output logic                                out_tlast
);
  import tcw_pkg::*;

  // Screen store: character in the low byte, attribute in the high byte
  logic [15:0]       cells_r [CELL_COUNT];
  logic [15:0]       rd_data_r;
  logic              mem_we, mem_re;
  logic [CELL_W-1:0] mem_waddr, mem_raddr;
  logic [15:0]       mem_wdata;

  logic [7:0]        color_r;
  logic              item_op_r;
  logic [7:0]        item_char_r;
  logic [IDX_W-1:0]  item_idx_r;
  logic              item_ok_r;

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [CELL_W-1:0] base_r, base_nxt;
  logic [CELL_W-1:0] cnt_r, cnt_nxt;

  logic              out_tvalid_r, out_tvalid_nxt;
  logic [7:0]        out_byte_r;
  logic              out_sv_r;
  logic [7:0]        out_char_r, out_attr_r;
  logic [OUT_COL_W-1:0] out_col_r;
  logic [OUT_ROW_W-1:0] out_row_r;
  logic              out_last_r;

  logic              is_nl, col_last, row_last;
  logic [CELL_W-1:0] pos;

  assign is_nl    = (item_op_r == OP_PRINT) && (item_char_r == NL_CODE);
  assign col_last = (col_r == COL_W'(COLUMNS - 1));
  assign row_last = (row_r == ROW_W'(ROWS - 1));
  assign pos      = base_r + CELL_W'(col_r);

  // Report status
  assign sts.op_read       = (item_op_r == OP_READ);
  assign sts.is_newline    = is_nl;
  assign sts.scroll_needed = (is_nl || col_last) && row_last;
  assign sts.copy_done     = (cnt_r == CELL_W'(COPY_N));
  assign sts.fill_done     = (cnt_r == CELL_W'(CELL_COUNT - 1));
  assign sts.out_free      = !out_tvalid_r || out_tready;

  // Attribute register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= COLOR_RESET;
    end else if (cfg_wen) begin
      color_r <= cfg_wdata;
    end
  end

  // Capture the accepted word
  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      item_op_r   <= in_tuser;
      item_char_r <= in_tdata[7:0];
      item_idx_r  <= in_tdata[8 +: IDX_W];
      item_ok_r   <= (32'(in_tdata[8 +: IDX_W]) < CELL_COUNT);
    end
  end

  // Select store write and read ports
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos;
    mem_wdata = {color_r, item_char_r};
    mem_re    = 1'b0;
    mem_raddr = CELL_W'(item_idx_r);
    if (cmd.exec_print && !is_nl) begin
      mem_we = 1'b1;
    end
    if (cmd.copy_step) begin
      // read one row ahead, write back the word fetched the cycle before
      mem_we    = (cnt_r != '0);
      mem_waddr = cnt_r - CELL_W'(1);
      mem_wdata = rd_data_r;
      mem_re    = !sts.copy_done;
      mem_raddr = cnt_r + CELL_W'(COLUMNS);
    end
    if (cmd.fill_step) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_r;
      mem_wdata = cmd.fill_blank ? {color_r, SPACE_CODE} : 16'h0000;
    end
    if (cmd.exec_read && item_ok_r) begin
      mem_re = 1'b1;
    end
  end

  // Screen store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cells_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= cells_r[mem_raddr];
    end
  end

  // Advance cursor and sweep counter
  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    base_nxt = base_r;
    cnt_nxt  = cnt_r;
    if (cmd.exec_print) begin
      if (is_nl || col_last) begin
        col_nxt = '0;
        if (!row_last) begin
          row_nxt  = row_r + ROW_W'(1);
          base_nxt = base_r + CELL_W'(COLUMNS);
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
    if (cmd.cnt_zero) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CELL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      base_r <= '0;
      cnt_r  <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      base_r <= base_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Result register: load when free, drop when taken
  assign out_tvalid_nxt = cmd.load_out ? 1'b1 : (out_tready ? 1'b0 : out_tvalid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_col_r <= OUT_COL_W'(col_r);
      out_row_r <= OUT_ROW_W'(row_r);
      if (item_op_r == OP_READ) begin
        out_byte_r <= 8'h00;
        out_sv_r   <= 1'b0;
        out_char_r <= item_ok_r ? rd_data_r[7:0]  : 8'h00;
        out_attr_r <= item_ok_r ? rd_data_r[15:8] : 8'h00;
        out_last_r <= 1'b1;
      end else begin
        out_byte_r <= cmd.out_cr ? CR_CODE : item_char_r;
        out_sv_r   <= 1'b1;
        out_char_r <= 8'h00;
        out_attr_r <= 8'h00;
        out_last_r <= cmd.out_cr || !is_nl;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0000, out_row_r, out_col_r, out_attr_r, out_char_r, out_byte_r};
  assign out_tuser  = out_sv_r;
  assign out_tlast  = out_last_r;

endmodule
